/* design/r2q_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// r2q_pkg
// Shared widths, types and helpers for the rotation matrix to quaternion unit.
// ----------------------------------------------------------------------------
package r2q_pkg;

	localparam int FRAC_BITS = 14;
	localparam int DW        = 16;               // matrix and quaternion element width
	localparam int VW        = DW + 2;           // unnormalized vector component
	localparam int SQ_W      = 2 * VW;           // square of one component
	localparam int SUM_W     = SQ_W + 2;         // sum of four squares, kept even
	localparam int ROOT_W    = SUM_W / 2;        // integer square root
	localparam int RREM_W    = ROOT_W + 3;       // square root partial remainder
	localparam int NUM_W     = VW + FRAC_BITS;   // divider numerator
	localparam int QW        = FRAC_BITS + 1;    // quotient magnitude, at most ONE
	localparam int DREM_W    = ROOT_W + 1;       // divider partial remainder
	localparam int NLANE     = 4;
	localparam int ONE_I     = 1 << FRAC_BITS;

	typedef logic signed [VW-1:0] vec_t;

	typedef struct packed {
		vec_t w;
		vec_t x;
		vec_t y;
		vec_t z;
		logic degen;
	} item_t;

	function automatic logic [VW-1:0] mag_f(input vec_t v);
		return v[VW-1] ? VW'(-v) : VW'(v);
	endfunction

endpackage
`default_nettype wire

/* design/r2q_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// r2q_front
// Accepts a matrix, picks the trace or the largest diagonal branch and forms
// the unnormalized quaternion vector and the degenerate flag.
// ----------------------------------------------------------------------------
module r2q_front import r2q_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output      logic                 in_stall,
	input  wire logic signed [DW-1:0] m00,
	input  wire logic signed [DW-1:0] m01,
	input  wire logic signed [DW-1:0] m02,
	input  wire logic signed [DW-1:0] m10,
	input  wire logic signed [DW-1:0] m11,
	input  wire logic signed [DW-1:0] m12,
	input  wire logic signed [DW-1:0] m20,
	input  wire logic signed [DW-1:0] m21,
	input  wire logic signed [DW-1:0] m22,
	output      item_t                item,
	output      logic                 item_valid,
	input  wire logic                 item_stall
);

	typedef enum logic [1:0] {AX_X, AX_Y, AX_Z} axis_t;

	localparam vec_t ONE = VW'(ONE_I);

	logic  valid_s1;
	item_t item_s1;
	item_t nxt;
	logic  adv;

	assign adv        = !valid_s1 || !item_stall;
	assign in_stall   = !adv;
	assign item       = item_s1;
	assign item_valid = valid_s1;

	always_comb begin
		vec_t  e00, e01, e02, e10, e11, e12, e20, e21, e22;
		vec_t  t, r;
		axis_t ax;
		e00 = VW'(m00); e01 = VW'(m01); e02 = VW'(m02);
		e10 = VW'(m10); e11 = VW'(m11); e12 = VW'(m12);
		e20 = VW'(m20); e21 = VW'(m21); e22 = VW'(m22);
		t   = e00 + e11 + e22;
		ax  = AX_X;
		if (e11 > e00) begin
			ax = AX_Y;
		end
		if (e22 > ((ax == AX_Y) ? e11 : e00)) begin
			ax = AX_Z;
		end
		nxt.degen = 1'b0;
		if (t > 0) begin
			r     = t + ONE;
			nxt.w = r;
			nxt.x = e21 - e12;
			nxt.y = e02 - e20;
			nxt.z = e10 - e01;
		end else begin
			case (ax)
				AX_Y: begin
					r     = e11 - e22 - e00 + ONE;
					nxt.y = r;
					nxt.z = e21 + e12;
					nxt.x = e01 + e10;
					nxt.w = e02 - e20;
				end
				AX_Z: begin
					r     = e22 - e00 - e11 + ONE;
					nxt.z = r;
					nxt.x = e02 + e20;
					nxt.y = e12 + e21;
					nxt.w = e10 - e01;
				end
				default: begin
					r     = e00 - e11 - e22 + ONE;
					nxt.x = r;
					nxt.y = e10 + e01;
					nxt.z = e20 + e02;
					nxt.w = e21 - e12;
				end
			endcase
		end
		// identity vector normalizes to the identity quaternion downstream
		if (r <= 0) begin
			nxt.w     = ONE;
			nxt.x     = '0;
			nxt.y     = '0;
			nxt.z     = '0;
			nxt.degen = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && in_valid) begin
			item_s1 <= nxt;
		end
	end

endmodule
`default_nettype wire

/* design/r2q_queue.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// r2q_queue
// Four-entry queue between the front and the back pipeline.
// ----------------------------------------------------------------------------
module r2q_queue import r2q_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire item_t push_item,
	input  wire logic  push_valid,
	output      logic  push_stall,
	output      item_t pop_item,
	output      logic  pop_valid,
	input  wire logic  pop_stall
);

	localparam int DEPTH = 4;
	localparam int AW    = $clog2(DEPTH);

	item_t         mem [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [AW:0]   cnt_q;
	logic          push;
	logic          pop;

	assign push_stall = (cnt_q == (AW+1)'(DEPTH));
	assign pop_valid  = (cnt_q != '0);
	assign push       = push_valid && !push_stall;
	assign pop        = pop_valid && !pop_stall;
	assign pop_item   = mem[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_item;
		end
	end

endmodule
`default_nettype wire

/* design/r2q_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// r2q_back
// Normalizes the vector: squares, sum, bit-per-stage square root, then four
// bit-per-stage rounded dividers, and the output register.
// ----------------------------------------------------------------------------
module r2q_back import r2q_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire item_t                item,
	input  wire logic                 item_valid,
	output      logic                 item_stall,
	output      logic signed [DW-1:0] qw,
	output      logic signed [DW-1:0] qx,
	output      logic signed [DW-1:0] qy,
	output      logic signed [DW-1:0] qz,
	output      logic                 degenerate,
	output      logic                 out_valid,
	input  wire logic                 out_stall
);

	localparam int NS = ROOT_W;
	localparam int ND = QW;

	logic adv;

	// stage 1: squares
	logic              valid_s1;
	item_t             item_s1;
	logic [SQ_W-1:0]   sq_s1 [NLANE];
	logic [VW-1:0]     mg_in [NLANE];

	// square root pipeline, index 0 holds the sum
	logic              sval_s [NS+1];
	item_t             sit_s  [NS+1];
	logic [SUM_W-1:0]  rad_s  [NS+1];
	logic [RREM_W-1:0] rrem_s [NS+1];
	logic [ROOT_W-1:0] root_s [NS+1];

	// divider pipeline, index 0 holds the numerators
	logic              dval_s [ND+1];
	logic              ddeg_s [ND+1];
	logic [ROOT_W-1:0] dd_s   [ND+1];
	logic [DREM_W-1:0] drem_s [ND+1][NLANE];
	logic [QW-1:0]     dlow_s [ND+1][NLANE];
	logic [QW-1:0]     qt_s   [ND+1][NLANE];
	logic              neg_s  [ND+1][NLANE];

	logic                 out_valid_q;
	logic signed [DW-1:0] q_q [NLANE];
	logic                 degen_q;

	assign adv        = !out_valid_q || !out_stall;
	assign item_stall = !adv;

	assign mg_in[0] = mag_f(item.w);
	assign mg_in[1] = mag_f(item.x);
	assign mg_in[2] = mag_f(item.y);
	assign mg_in[3] = mag_f(item.z);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			sval_s[0] <= 1'b0;
		end else if (adv) begin
			valid_s1  <= item_valid;
			sval_s[0] <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			item_s1 <= item;
			for (int k = 0; k < NLANE; k++) begin
				sq_s1[k] <= SQ_W'(mg_in[k]) * SQ_W'(mg_in[k]);
			end
			sit_s[0]  <= item_s1;
			rad_s[0]  <= SUM_W'(sq_s1[0]) + SUM_W'(sq_s1[1])
				+ SUM_W'(sq_s1[2]) + SUM_W'(sq_s1[3]);
			rrem_s[0] <= '0;
			root_s[0] <= '0;
		end
	end

	for (genvar g = 0; g < NS; g++) begin : g_sqrt
		logic [RREM_W-1:0] remx;
		logic [RREM_W-1:0] trial;
		logic              ge;

		assign remx  = {rrem_s[g][RREM_W-3:0], rad_s[g][SUM_W-1 -: 2]};
		assign trial = RREM_W'({root_s[g], 2'b01});
		assign ge    = (remx >= trial);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sval_s[g+1] <= 1'b0;
			end else if (adv) begin
				sval_s[g+1] <= sval_s[g];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				sit_s[g+1]  <= sit_s[g];
				rad_s[g+1]  <= rad_s[g] << 2;
				rrem_s[g+1] <= ge ? (remx - trial) : remx;
				root_s[g+1] <= {root_s[g][ROOT_W-2:0], ge};
			end
		end
	end

	// numerator: mag * ONE + n/2, split into a head below n and the bits to shift in
	vec_t             lane_v [NLANE];
	logic [NUM_W-1:0] num    [NLANE];

	assign lane_v[0] = sit_s[NS].w;
	assign lane_v[1] = sit_s[NS].x;
	assign lane_v[2] = sit_s[NS].y;
	assign lane_v[3] = sit_s[NS].z;

	for (genvar k = 0; k < NLANE; k++) begin : g_num
		assign num[k] = {mag_f(lane_v[k]), FRAC_BITS'(0)}
			+ NUM_W'(root_s[NS] >> 1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dval_s[0] <= 1'b0;
		end else if (adv) begin
			dval_s[0] <= sval_s[NS];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ddeg_s[0] <= sit_s[NS].degen;
			dd_s[0]   <= root_s[NS];
			for (int k = 0; k < NLANE; k++) begin
				drem_s[0][k] <= DREM_W'(num[k][NUM_W-1:QW]);
				dlow_s[0][k] <= num[k][QW-1:0];
				qt_s[0][k]   <= '0;
				neg_s[0][k]  <= lane_v[k][VW-1];
			end
		end
	end

	for (genvar g = 0; g < ND; g++) begin : g_div
		logic [DREM_W-1:0] remx [NLANE];
		logic              ge   [NLANE];

		for (genvar k = 0; k < NLANE; k++) begin : g_lane
			assign remx[k] = {drem_s[g][k][DREM_W-2:0], dlow_s[g][k][QW-1]};
			assign ge[k]   = (remx[k] >= DREM_W'(dd_s[g]));
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dval_s[g+1] <= 1'b0;
			end else if (adv) begin
				dval_s[g+1] <= dval_s[g];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				ddeg_s[g+1] <= ddeg_s[g];
				dd_s[g+1]   <= dd_s[g];
				for (int k = 0; k < NLANE; k++) begin
					drem_s[g+1][k] <= ge[k] ? (remx[k] - DREM_W'(dd_s[g])) : remx[k];
					dlow_s[g+1][k] <= dlow_s[g][k] << 1;
					qt_s[g+1][k]   <= {qt_s[g][k][QW-2:0], ge[k]};
					neg_s[g+1][k]  <= neg_s[g][k];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= dval_s[ND];
		end
	end

	// quotient never exceeds ONE, so it fits without clamping
	always_ff @(posedge clk) begin
		if (adv) begin
			degen_q <= ddeg_s[ND];
			for (int k = 0; k < NLANE; k++) begin
				q_q[k] <= neg_s[ND][k] ? -DW'({1'b0, qt_s[ND][k]})
					: DW'({1'b0, qt_s[ND][k]});
			end
		end
	end

	assign qw         = q_q[0];
	assign qx         = q_q[1];
	assign qy         = q_q[2];
	assign qz         = q_q[3];
	assign degenerate = degen_q;
	assign out_valid  = out_valid_q;

endmodule
`default_nettype wire

/* design/quaternion_from_rotation_matrix_unit.sv */
`default_nettype none
// Pipeline: the front register loads at the input transfer edge, then the queue
// and 38 back stages: squares, sum, 19 square root steps, numerator, 15 divide
// steps, output.
// Throughput: one matrix per cycle while out_stall is low; root and divider give one bit per stage.
// Reset: arst_n clears all valid bits and queue pointers; payload is not reset.
// ----------------------------------------------------------------------------
// quaternion_from_rotation_matrix_unit
// Converts a Q2.14 rotation matrix into a normalized Q2.14 quaternion.
// ----------------------------------------------------------------------------
module quaternion_from_rotation_matrix_unit import r2q_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output      logic                 in_stall,
	input  wire logic signed [DW-1:0] m00,
	input  wire logic signed [DW-1:0] m01,
	input  wire logic signed [DW-1:0] m02,
	input  wire logic signed [DW-1:0] m10,
	input  wire logic signed [DW-1:0] m11,
	input  wire logic signed [DW-1:0] m12,
	input  wire logic signed [DW-1:0] m20,
	input  wire logic signed [DW-1:0] m21,
	input  wire logic signed [DW-1:0] m22,
	output      logic                 out_valid,
	input  wire logic                 out_stall,
	output      logic signed [DW-1:0] qw,
	output      logic signed [DW-1:0] qx,
	output      logic signed [DW-1:0] qy,
	output      logic signed [DW-1:0] qz,
	output      logic                 degenerate
);

	item_t f_item;
	logic  f_valid;
	logic  f_stall;
	item_t b_item;
	logic  b_valid;
	logic  b_stall;

	r2q_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.m00        (m00),
		.m01        (m01),
		.m02        (m02),
		.m10        (m10),
		.m11        (m11),
		.m12        (m12),
		.m20        (m20),
		.m21        (m21),
		.m22        (m22),
		.item       (f_item),
		.item_valid (f_valid),
		.item_stall (f_stall)
	);

	r2q_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_item  (f_item),
		.push_valid (f_valid),
		.push_stall (f_stall),
		.pop_item   (b_item),
		.pop_valid  (b_valid),
		.pop_stall  (b_stall)
	);

	r2q_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (b_item),
		.item_valid (b_valid),
		.item_stall (b_stall),
		.qw         (qw),
		.qx         (qx),
		.qy         (qy),
		.qz         (qz),
		.degenerate (degenerate),
		.out_valid  (out_valid),
		.out_stall  (out_stall)
	);

endmodule
`default_nettype wire
